// File: rtl/sph_pkg.sv
// ----------------------------------------------------------------------------
// Scaled pixel histogram package
// Types, constants and codes shared by the histogram front end, queue and
// back end.
// ----------------------------------------------------------------------------
package sph_pkg;

   // Default sizing of the counter table.
   localparam int MAX_BINS_DEFAULT    = 256;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Largest table the design supports, and the bin field width that covers it.
   localparam int MAX_BINS_LIMIT = 4096;
   localparam int BIN_FIELD_W    = $clog2(MAX_BINS_LIMIT);

   // Configuration register widths, reset values and indexes.
   localparam int RANGE_MAX_W = 17;
   localparam int BIN_COUNT_W = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;

   localparam logic [RANGE_MAX_W-1:0] RANGE_MAX_RESET = 17'd256;
   localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 9'd256;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MAX = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COUNT = 1'b1;

   // Payload field widths.
   localparam int OPERATION_W   = 2;
   localparam int PIXEL_W       = 8;
   localparam int READ_BIN_W    = 8;
   localparam int COUNT_VALUE_W = 32;
   localparam int BIN_INDEX_W   = 8;

   // Operation codes.
   localparam logic [OPERATION_W-1:0] OP_COUNT      = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_READ       = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_READ_CLEAR = 2'd2;

   // Scaling divider: the dividend pixel * bin_count fits in 17 bits.
   localparam int DIV_W      = PIXEL_W + BIN_COUNT_W;
   localparam int DIV_STEPS  = DIV_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   // Command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_COUNT,
      CMD_READ,
      CMD_READ_CLEAR,
      CMD_REJECT,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [BIN_FIELD_W-1:0]  bin;
      logic                    done;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIVIDE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

endpackage

// File: rtl/scaled_pixel_histogram.sv
// ----------------------------------------------------------------------------
// Scaled pixel histogram
// Counts pixels into saturating bin counters and serves bin reads and clears.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ channel and each produces exactly one result on
// the rsp_ channel, in order. A transfer happens on a clock edge where valid
// is high and stall is low. Operation 0 counts a pixel into bin
// floor(pixel * bin_count / range_max); operations 1 and 2 read a bin, and
// operation 2 also clears it. The csr_ port writes range_max (index 0) and
// bin_count (index 1); write it only while no item is in flight.
// A pixel count goes through the bit-serial scaling divider, the queue and
// the table update; a read goes straight into the queue when taken and then
// through the table update. The divider sets the pace for counts: no new item
// is taken until the divided pixel's command is queued. The back end reads a
// bin, then does any write to it and loads the result before it pops the next
// command. After reset the table is swept to zero, one bin per cycle;
// req_stall is high during the sweep. When the receiver stalls, the result
// waits in the output register, the command queue fills and then req_stall
// rises. Reset restores range_max and bin_count to 256.
// ----------------------------------------------------------------------------
module scaled_pixel_histogram #(
   parameter int MAX_BINS    = sph_pkg::MAX_BINS_DEFAULT,
   parameter int COUNT_WIDTH = sph_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [sph_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sph_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sph_pkg::OPERATION_W-1:0]      req_operation,
   input  logic [sph_pkg::PIXEL_W-1:0]          req_pixel,
   input  logic [sph_pkg::READ_BIN_W-1:0]       req_read_bin,
   input  logic                                 req_last_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sph_pkg::COUNT_VALUE_W-1:0]    rsp_count_value,
   output logic [sph_pkg::BIN_INDEX_W-1:0]      rsp_bin_index,
   output logic                                 rsp_out_of_range,
   output logic                                 rsp_frame_done
);

   logic [sph_pkg::RANGE_MAX_W-1:0] range_max_ff, range_max_in;
   logic [sph_pkg::BIN_COUNT_W-1:0] bin_count_ff, bin_count_in;

   logic                      q_push;
   logic                      q_pop;
   sph_pkg::cmd_type          q_data;
   sph_pkg::cmd_type          q_head;
   sph_pkg::queue_status_type q_status;
   logic                      clearing;

   always_comb begin
      range_max_in = range_max_ff;
      bin_count_in = bin_count_ff;
      if (csr_write) begin
         case (csr_index)
            sph_pkg::CSR_RANGE_MAX: range_max_in = csr_wdata[sph_pkg::RANGE_MAX_W-1:0];
            sph_pkg::CSR_BIN_COUNT: bin_count_in = csr_wdata[sph_pkg::BIN_COUNT_W-1:0];
            default: begin
               range_max_in = range_max_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_max_ff <= sph_pkg::RANGE_MAX_RESET;
         bin_count_ff <= sph_pkg::BIN_COUNT_RESET;
      end else begin
         range_max_ff <= range_max_in;
         bin_count_ff <= bin_count_in;
      end
   end

   sph_front #(
      .MAX_BINS (MAX_BINS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_pixel      (req_pixel),
      .req_read_bin   (req_read_bin),
      .req_last_pixel (req_last_pixel),
      .range_max      (range_max_ff),
      .bin_count      (bin_count_ff),
      .hold_off       (clearing),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_data         (q_data)
   );

   sph_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   sph_back #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_value  (rsp_count_value),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_frame_done   (rsp_frame_done)
   );

   a_no_push_when_full: assert property (
      @(posedge clock) disable iff (reset) q_push |-> !q_status.full
   ) else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (
      @(posedge clock) disable iff (reset) q_pop |-> !q_status.empty
   ) else $error("command popped from an empty queue");

   a_stall_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> req_stall
   ) else $error("item taken during the table sweep");

   a_reject_is_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_count_value == '0 && rsp_bin_index == '0)
   ) else $error("out-of-range result carries a count or bin");

endmodule

// File: rtl/sph_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sph_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO that decouples the classifying front end from the table update.
// ----------------------------------------------------------------------------
module sph_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sph_pkg::cmd_type          push_data,
   input  logic                      pop,
   output sph_pkg::cmd_type          head,
   output sph_pkg::queue_status_type status
);

   localparam int DEPTH  = sph_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   sph_pkg::cmd_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: rtl/sph_front.sv
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts items, works out the bin of a pixel with a bit-serial divider and
// queues one command per item for the back end.
// ----------------------------------------------------------------------------
module sph_front #(
   parameter int MAX_BINS = sph_pkg::MAX_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sph_pkg::OPERATION_W-1:0]     req_operation,
   input  logic [sph_pkg::PIXEL_W-1:0]         req_pixel,
   input  logic [sph_pkg::READ_BIN_W-1:0]      req_read_bin,
   input  logic                                req_last_pixel,
   input  logic [sph_pkg::RANGE_MAX_W-1:0]     range_max,
   input  logic [sph_pkg::BIN_COUNT_W-1:0]     bin_count,
   input  logic                                hold_off,
   input  sph_pkg::queue_status_type           q_status,
   output logic                                q_push,
   output sph_pkg::cmd_type                    q_data
);

   localparam int DIV_W  = sph_pkg::DIV_W;
   localparam int STEP_W = sph_pkg::DIV_STEP_W;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(sph_pkg::DIV_STEPS - 1);
   localparam logic [DIV_W-1:0]  MAX_BINS_Q = DIV_W'(MAX_BINS);

   sph_pkg::front_state_type state_ff, state_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     done_ff, done_in;

   logic                     accept;
   logic [DIV_W:0]           shifted;
   logic [DIV_W:0]           divisor;

   // One quotient bit per cycle: the dividend shifts out of the top of the
   // quotient register while quotient bits shift in at the bottom.
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign divisor = {1'b0, range_max};

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      done_in   = done_ff;
      q_push    = 1'b0;
      q_data.kind = sph_pkg::CMD_NOP;
      q_data.bin  = '0;
      q_data.done = req_last_pixel;
      req_stall = (state_ff != sph_pkg::FR_IDLE) || q_status.full || hold_off;
      accept    = req_valid && !req_stall;

      case (state_ff)
         sph_pkg::FR_IDLE: begin
            if (accept) begin
               case (req_operation)
                  sph_pkg::OP_COUNT: begin
                     if (range_max != '0) begin
                        quo_in   = DIV_W'({{sph_pkg::BIN_COUNT_W{1'b0}}, req_pixel}
                                          * {{sph_pkg::PIXEL_W{1'b0}}, bin_count});
                        rem_in   = '0;
                        step_in  = '0;
                        done_in  = req_last_pixel;
                        state_in = sph_pkg::FR_DIVIDE;
                     end else begin
                        q_data.kind = sph_pkg::CMD_REJECT;
                        q_push      = 1'b1;
                     end
                  end
                  sph_pkg::OP_READ, sph_pkg::OP_READ_CLEAR: begin
                     if (int'(req_read_bin) < MAX_BINS) begin
                        q_data.kind = (req_operation == sph_pkg::OP_READ) ?
                                      sph_pkg::CMD_READ : sph_pkg::CMD_READ_CLEAR;
                        q_data.bin  = sph_pkg::BIN_FIELD_W'(req_read_bin);
                     end else begin
                        q_data.kind = sph_pkg::CMD_REJECT;
                     end
                     q_push = 1'b1;
                  end
                  default: begin
                     q_data.kind = sph_pkg::CMD_NOP;
                     q_push      = 1'b1;
                  end
               endcase
            end
         end
         sph_pkg::FR_DIVIDE: begin
            if (shifted >= divisor) begin
               rem_in = DIV_W'(shifted - divisor);
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = sph_pkg::FR_PUSH;
            end
         end
         sph_pkg::FR_PUSH: begin
            q_data.done = done_ff;
            if (quo_ff >= DIV_W'(bin_count) || quo_ff >= MAX_BINS_Q) begin
               q_data.kind = sph_pkg::CMD_REJECT;
            end else begin
               q_data.kind = sph_pkg::CMD_COUNT;
               q_data.bin  = quo_ff[sph_pkg::BIN_FIELD_W-1:0];
            end
            if (!q_status.full) begin
               q_push   = 1'b1;
               state_in = sph_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = sph_pkg::FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sph_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      done_ff <= done_in;
   end

endmodule

// File: rtl/sph_back.sv
// ----------------------------------------------------------------------------
// Histogram back end
// Clears the counter table after reset, then carries out queued commands as
// read-modify-write cycles on the table and holds the result for transfer.
// ----------------------------------------------------------------------------
module sph_back #(
   parameter int MAX_BINS    = sph_pkg::MAX_BINS_DEFAULT,
   parameter int COUNT_WIDTH = sph_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sph_pkg::queue_status_type            q_status,
   input  sph_pkg::cmd_type                     q_head,
   output logic                                 q_pop,
   output logic                                 clearing,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sph_pkg::COUNT_VALUE_W-1:0]    rsp_count_value,
   output logic [sph_pkg::BIN_INDEX_W-1:0]      rsp_bin_index,
   output logic                                 rsp_out_of_range,
   output logic                                 rsp_frame_done
);

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int EXT_W = (COUNT_WIDTH > sph_pkg::COUNT_VALUE_W) ?
                          COUNT_WIDTH : sph_pkg::COUNT_VALUE_W;

   sph_pkg::back_state_type state_ff, state_in;
   logic [BIN_W-1:0]        clr_addr_ff, clr_addr_in;
   sph_pkg::cmd_type        cmd_ff, cmd_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [sph_pkg::COUNT_VALUE_W-1:0] rsp_count_value_ff, rsp_count_value_in;
   logic [sph_pkg::BIN_INDEX_W-1:0]   rsp_bin_index_ff, rsp_bin_index_in;
   logic                    rsp_out_of_range_ff, rsp_out_of_range_in;
   logic                    rsp_frame_done_ff, rsp_frame_done_in;

   logic                    wr_en;
   logic [BIN_W-1:0]        wr_addr;
   logic [COUNT_WIDTH-1:0]  wr_data;
   logic                    rd_en;
   logic [BIN_W-1:0]        rd_addr;
   logic [COUNT_WIDTH-1:0]  rd_data;

   logic [COUNT_WIDTH-1:0]  incremented;
   logic [EXT_W-1:0]        rd_ext;
   logic [EXT_W-1:0]        inc_ext;
   logic                    out_free;

   sph_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_BINS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The counter saturates at all ones.
   assign incremented = (&rd_data) ? rd_data : rd_data + 1'b1;
   assign rd_ext      = EXT_W'(rd_data);
   assign inc_ext     = EXT_W'(incremented);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in            = state_ff;
      clr_addr_in         = clr_addr_ff;
      cmd_in              = cmd_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_count_value_in  = rsp_count_value_ff;
      rsp_bin_index_in    = rsp_bin_index_ff;
      rsp_out_of_range_in = rsp_out_of_range_ff;
      rsp_frame_done_in   = rsp_frame_done_ff;
      wr_en               = 1'b0;
      wr_addr             = cmd_ff.bin[BIN_W-1:0];
      wr_data             = '0;
      rd_en               = 1'b0;
      rd_addr             = q_head.bin[BIN_W-1:0];
      q_pop               = 1'b0;
      clearing            = 1'b0;

      case (state_ff)
         sph_pkg::BK_CLEAR: begin
            clearing    = 1'b1;
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == BIN_W'(MAX_BINS - 1)) begin
               state_in = sph_pkg::BK_IDLE;
            end
         end
         sph_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = q_head;
               state_in = sph_pkg::BK_UPDATE;
            end
         end
         sph_pkg::BK_UPDATE: begin
            // The read data holds until the output register is free.
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_frame_done_in   = cmd_ff.done;
               rsp_count_value_in  = '0;
               rsp_bin_index_in    = '0;
               rsp_out_of_range_in = 1'b0;
               case (cmd_ff.kind)
                  sph_pkg::CMD_COUNT: begin
                     wr_en              = 1'b1;
                     wr_data            = incremented;
                     rsp_count_value_in = inc_ext[sph_pkg::COUNT_VALUE_W-1:0];
                     rsp_bin_index_in   = cmd_ff.bin[sph_pkg::BIN_INDEX_W-1:0];
                  end
                  sph_pkg::CMD_READ: begin
                     rsp_count_value_in = rd_ext[sph_pkg::COUNT_VALUE_W-1:0];
                     rsp_bin_index_in   = cmd_ff.bin[sph_pkg::BIN_INDEX_W-1:0];
                  end
                  sph_pkg::CMD_READ_CLEAR: begin
                     wr_en              = 1'b1;
                     wr_data            = '0;
                     rsp_count_value_in = rd_ext[sph_pkg::COUNT_VALUE_W-1:0];
                     rsp_bin_index_in   = cmd_ff.bin[sph_pkg::BIN_INDEX_W-1:0];
                  end
                  sph_pkg::CMD_REJECT: begin
                     rsp_out_of_range_in = 1'b1;
                  end
                  default: begin
                     rsp_out_of_range_in = 1'b0;
                  end
               endcase
               state_in = sph_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = sph_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sph_pkg::BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff              <= cmd_in;
      rsp_count_value_ff  <= rsp_count_value_in;
      rsp_bin_index_ff    <= rsp_bin_index_in;
      rsp_out_of_range_ff <= rsp_out_of_range_in;
      rsp_frame_done_ff   <= rsp_frame_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_value  = rsp_count_value_ff;
   assign rsp_bin_index    = rsp_bin_index_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;
   assign rsp_frame_done   = rsp_frame_done_ff;

endmodule

// File: tb/scaled_pixel_histogram_checker.sv
// ----------------------------------------------------------------------------
// Scaled pixel histogram checker
// Watches the csr_, req_ and rsp_ ports of the histogram. Keeps its own copy
// of the bin table and of the scaling registers. For each request transfer it
// works out the reply. Each reply transfer is compared field by field with the
// oldest reply still outstanding.
// ----------------------------------------------------------------------------
module scaled_pixel_histogram_checker
   import sph_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [OPERATION_W-1:0]     req_operation,
   input  logic [PIXEL_W-1:0]         req_pixel,
   input  logic [READ_BIN_W-1:0]      req_read_bin,
   input  logic                       req_last_pixel,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [COUNT_VALUE_W-1:0]   rsp_count_value,
   input  logic [BIN_INDEX_W-1:0]     rsp_bin_index,
   input  logic                       rsp_out_of_range,
   input  logic                       rsp_frame_done,
   output int                         mismatches,
   output int                         tallies_left
);

   localparam int TABLE_SIZE = MAX_BINS_DEFAULT;
   localparam int TABLE_AW   = $clog2(TABLE_SIZE);

   typedef struct packed {
      logic [COUNT_VALUE_W-1:0] count;
      logic [BIN_INDEX_W-1:0]   bin;
      logic                     out_of_range;
      logic                     frame_done;
   } bin_tally_type;

   logic [COUNT_WIDTH_DEFAULT-1:0] bin_table [TABLE_SIZE];
   logic [RANGE_MAX_W-1:0]         range_max_q = RANGE_MAX_RESET;
   logic [BIN_COUNT_W-1:0]         bin_count_q = BIN_COUNT_RESET;
   bin_tally_type                  queued_tallies [$];
   int                             fail_tally = 0;
   int                             queued_count = 0;

   assign mismatches   = fail_tally;
   assign tallies_left = queued_count;

   task automatic flag_mismatch(input string what);
      $display("%0t: histogram mismatch: %s", $time, what);
      fail_tally = fail_tally + 1;
   endtask

   // Applies one item to the bin table and returns the reply it causes.
   function automatic bin_tally_type tally_item(input logic [OPERATION_W-1:0] op,
                                                input logic [PIXEL_W-1:0] pix,
                                                input logic [READ_BIN_W-1:0] rbin,
                                                input logic last);
      bin_tally_type         tally;
      int unsigned           scaled;
      int unsigned           bin;
      logic [TABLE_AW-1:0]   slot;
      tally = '0;
      tally.frame_done = last;
      case (op)
         OP_COUNT: begin
            if (range_max_q == '0) begin
               tally.out_of_range = 1'b1;
            end else begin
               scaled = 32'(pix) * 32'(bin_count_q);
               bin    = scaled / 32'(range_max_q);
               if (bin >= 32'(bin_count_q) || bin >= TABLE_SIZE) begin
                  tally.out_of_range = 1'b1;
               end else begin
                  slot = bin[TABLE_AW-1:0];
                  if (bin_table[slot] != '1)
                     bin_table[slot] = bin_table[slot] + 1'b1;
                  tally.count = bin_table[slot][COUNT_VALUE_W-1:0];
                  tally.bin   = bin[BIN_INDEX_W-1:0];
               end
            end
         end
         OP_READ, OP_READ_CLEAR: begin
            if (32'(rbin) >= TABLE_SIZE) begin
               tally.out_of_range = 1'b1;
            end else begin
               tally.count = bin_table[rbin][COUNT_VALUE_W-1:0];
               tally.bin   = rbin;
               if (op == OP_READ_CLEAR)
                  bin_table[rbin] = '0;
            end
         end
         default: ;
      endcase
      return tally;
   endfunction

   always @(posedge clock) begin
      bin_tally_type want;
      if (reset) begin
         foreach (bin_table[i])
            bin_table[i] = '0;
         range_max_q = RANGE_MAX_RESET;
         bin_count_q = BIN_COUNT_RESET;
         queued_tallies.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_RANGE_MAX: range_max_q = csr_wdata[RANGE_MAX_W-1:0];
               CSR_BIN_COUNT: bin_count_q = csr_wdata[BIN_COUNT_W-1:0];
               default: ;
            endcase
         end
         // Replies are taken before requests so that a request never
         // matches a reply in its own cycle.
         if (rsp_valid && !rsp_stall) begin
            if (queued_tallies.size() == 0) begin
               flag_mismatch("reply transfer with no request outstanding");
            end else begin
               want = queued_tallies.pop_front();
               if (rsp_count_value !== want.count)
                  flag_mismatch($sformatf("count_value %0h, wanted %0h",
                                          rsp_count_value, want.count));
               if (rsp_bin_index !== want.bin)
                  flag_mismatch($sformatf("bin_index %0d, wanted %0d",
                                          rsp_bin_index, want.bin));
               if (rsp_out_of_range !== want.out_of_range)
                  flag_mismatch($sformatf("out_of_range %b, wanted %b",
                                          rsp_out_of_range, want.out_of_range));
               if (rsp_frame_done !== want.frame_done)
                  flag_mismatch($sformatf("frame_done %b, wanted %b",
                                          rsp_frame_done, want.frame_done));
            end
         end
         if (req_valid && !req_stall)
            queued_tallies.push_back(tally_item(req_operation, req_pixel,
                                                req_read_bin, req_last_pixel));
      end
      queued_count <= queued_tallies.size();
   end

endmodule

// File: tb/scaled_pixel_histogram_tb.sv
// ----------------------------------------------------------------------------
// Scaled pixel histogram testbench
// Drives directed probes of the scaling extremes, then random pixel, read and
// clear traffic under a series of register settings and idling mixes. A
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module scaled_pixel_histogram_tb;
   import sph_pkg::*;

   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 138;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;
   logic                       req_valid;
   logic                       req_stall;
   logic [OPERATION_W-1:0]     req_operation;
   logic [PIXEL_W-1:0]         req_pixel;
   logic [READ_BIN_W-1:0]      req_read_bin;
   logic                       req_last_pixel;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [COUNT_VALUE_W-1:0]   rsp_count_value;
   logic [BIN_INDEX_W-1:0]     rsp_bin_index;
   logic                       rsp_out_of_range;
   logic                       rsp_frame_done;
   int                         mismatches;
   int                         tallies_left;
   int                         tx_idle_pct = 0;
   int                         rx_idle_pct = 0;
   int unsigned                cur_bins = 32'(BIN_COUNT_RESET);

   always #5 clock = ~clock;

   scaled_pixel_histogram dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_pixel        (req_pixel),
      .req_read_bin     (req_read_bin),
      .req_last_pixel   (req_last_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_value  (rsp_count_value),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_frame_done   (rsp_frame_done)
   );

   scaled_pixel_histogram_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_pixel        (req_pixel),
      .req_read_bin     (req_read_bin),
      .req_last_pixel   (req_last_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_value  (rsp_count_value),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_frame_done   (rsp_frame_done),
      .mismatches       (mismatches),
      .tallies_left     (tallies_left)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   task automatic push_item(input logic [OPERATION_W-1:0] op,
                            input logic [PIXEL_W-1:0] pix,
                            input logic [READ_BIN_W-1:0] rbin,
                            input logic last);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_pixel      <= pix;
      req_read_bin   <= rbin;
      req_last_pixel <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Waits until every reply has come back, then lets the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tallies_left != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_scaling(input logic [RANGE_MAX_W-1:0] range_val,
                               input logic [BIN_COUNT_W-1:0] bins_val);
      settle();
      csr_write <= 1'b1;
      csr_index <= CSR_RANGE_MAX;
      csr_wdata <= range_val;
      @(posedge clock);
      csr_index <= CSR_BIN_COUNT;
      csr_wdata <= {{(CSR_DATA_W-BIN_COUNT_W){1'b0}}, bins_val};
      @(posedge clock);
      csr_write <= 1'b0;
      cur_bins = 32'(bins_val);
   endtask

   // Three items: counts at both ends of the pixel range and a read of
   // bin 200.
   task automatic probe_scaling(input logic [RANGE_MAX_W-1:0] range_val,
                                input logic [BIN_COUNT_W-1:0] bins_val);
      load_scaling(range_val, bins_val);
      push_item(OP_COUNT, 8'd0, 8'd0, 1'b0);
      push_item(OP_COUNT, 8'd255, 8'd255, 1'b0);
      push_item(OP_READ, 8'd0, 8'd200, 1'b1);
   endtask

   task automatic push_random_item();
      int                      pick;
      logic [OPERATION_W-1:0]  op;
      logic [READ_BIN_W-1:0]   rbin;
      logic                    last;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         op = OP_COUNT;
      else if (pick < 78)
         op = OP_READ;
      else if (pick < 95)
         op = OP_READ_CLEAR;
      else
         op = OP_UNUSED;
      // Half the reads aim at bins in use, where counts build up.
      if (cur_bins != 0 && $urandom_range(0, 1) == 0)
         rbin = READ_BIN_W'($urandom_range(0, (cur_bins > 256) ? 255 : cur_bins - 1));
      else
         rbin = READ_BIN_W'($urandom_range(0, 255));
      last = ($urandom_range(0, 7) == 0);
      push_item(op, PIXEL_W'($urandom_range(0, 255)), rbin, last);
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write      <= 1'b0;
      csr_index      <= CSR_RANGE_MAX;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_operation  <= OP_COUNT;
      req_pixel      <= '0;
      req_read_bin   <= '0;
      req_last_pixel <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 23;
      rx_idle_pct = 62;

      // Reset scaling: one bin per intensity.
      push_item(OP_COUNT, 8'd0, 8'd0, 1'b0);
      push_item(OP_COUNT, 8'd255, 8'd0, 1'b1);
      push_item(OP_COUNT, 8'd255, 8'd0, 1'b0);
      push_item(OP_READ, 8'd0, 8'd255, 1'b0);
      push_item(OP_READ_CLEAR, 8'd0, 8'd255, 1'b0);
      push_item(OP_READ, 8'd0, 8'd255, 1'b0);
      push_item(OP_READ_CLEAR, 8'd255, 8'd0, 1'b1);
      push_item(OP_UNUSED, 8'd255, 8'd255, 1'b1);

      probe_scaling(17'd1, 9'd1);
      probe_scaling(17'd0, 9'd256);
      probe_scaling(17'd256, 9'd0);
      probe_scaling(17'd65536, 9'd256);
      probe_scaling(17'd256, 9'd511);
      probe_scaling(17'h1FFFF, 9'h1FF);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < SEGMENTS / 3) begin
            tx_idle_pct = 23;
            rx_idle_pct = 62;
         end else if (seg < 2 * SEGMENTS / 3) begin
            tx_idle_pct = 62;
            rx_idle_pct = 23;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case ($urandom_range(0, 5))
            0: load_scaling(RANGE_MAX_W'($urandom_range(1, 16)),
                            BIN_COUNT_W'($urandom_range(1, 16)));
            1: load_scaling(RANGE_MAX_W'($urandom_range(1, 300)),
                            BIN_COUNT_W'($urandom_range(1, 256)));
            2: load_scaling(RANGE_MAX_W'($urandom_range(0, 131071)),
                            BIN_COUNT_W'($urandom_range(0, 511)));
            3: load_scaling(RANGE_MAX_RESET, BIN_COUNT_RESET);
            4: load_scaling(RANGE_MAX_W'($urandom_range(1, 255)), 9'd256);
            default: load_scaling(RANGE_MAX_RESET, BIN_COUNT_W'($urandom_range(2, 511)));
         endcase
         for (int n = 0; n < SEGMENT_ITEMS; n++)
            push_random_item();
      end

      settle();
      if (mismatches == 0 && tallies_left == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/sph_pkg.sv
rtl/sph_ram.sv
rtl/sph_queue.sv
rtl/sph_front.sv
rtl/sph_back.sv
rtl/scaled_pixel_histogram.sv
tb/scaled_pixel_histogram_checker.sv
tb/scaled_pixel_histogram_tb.sv
